FILE: hdl/calendar_day_normalizer_top_macros.svh
// Assertion macros used by the RTL top module.
`ifndef CALENDAR_DAY_NORMALIZER_TOP_MACROS_SVH
`define CALENDAR_DAY_NORMALIZER_TOP_MACROS_SVH

`ifndef SYNTH

`define CDN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("calendar day normalizer check failed");

`define CDN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("calendar day normalizer implication failed");

`define CDN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("calendar day normalizer sequence failed");

`else

`define CDN_ASSERT(lbl, prop)

`define CDN_ASSERT_IMPL(lbl, ante, cons)

`define CDN_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hdl/cdn_pkg.sv
package cdn_pkg;

  localparam int unsigned YEAR_BITS   = 12;
  localparam int unsigned DAY_BITS    = 11;
  localparam int unsigned MONTH_BITS  = 4;
  localparam int unsigned NDAY_BITS   = 5;
  localparam int unsigned PACKED_BITS = YEAR_BITS + 9;

  localparam logic [YEAR_BITS-1:0]  YEAR_MAX  = {YEAR_BITS{1'b1}};
  localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_BITS-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_BITS-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_BITS-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_BITS-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

  localparam logic [NDAY_BITS-1:0] LEN_31 = 5'd31;
  localparam logic [NDAY_BITS-1:0] LEN_30 = 5'd30;
  localparam logic [NDAY_BITS-1:0] LEN_29 = 5'd29;
  localparam logic [NDAY_BITS-1:0] LEN_28 = 5'd28;
  localparam logic [NDAY_BITS-1:0] DAY_FIRST = 5'd1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_e;

  function automatic logic [NDAY_BITS-1:0] month_len(
    input logic [1:0]            year_lsb,
    input logic [MONTH_BITS-1:0] month
  );
    logic [NDAY_BITS-1:0] len;
    unique case (month)
      MONTH_FEB: len = (year_lsb == 2'b00) ? LEN_29 : LEN_28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
      default: len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/cdn_if.sv
interface cdn_in_if import cdn_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [YEAR_BITS-1:0]        start_year;
  logic [MONTH_BITS-1:0]       start_month;
  logic signed [DAY_BITS-1:0]  requested_day;

  modport source (output valid, output start_year, output start_month,
                  output requested_day, input ready);
  modport sink   (input valid, input start_year, input start_month,
                  input requested_day, output ready);
endinterface

interface cdn_out_if import cdn_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [YEAR_BITS-1:0]    norm_year;
  logic [MONTH_BITS-1:0]   norm_month;
  logic [NDAY_BITS-1:0]    norm_day;
  logic [PACKED_BITS-1:0]  packed_date;
  logic                    year_range_error;

  modport source (output valid, output norm_year, output norm_month, output norm_day,
                  output packed_date, output year_range_error, input ready);
  modport sink   (input valid, input norm_year, input norm_month, input norm_day,
                  input packed_date, input year_range_error, output ready);
endinterface

FILE: hdl/calendar_day_normalizer_top.sv
// Channel  Dir  Payload
// in_i     in   start_year, start_month, requested_day
// out_o    out  norm_year, norm_month, norm_day, packed_date, year_range_error
//
// One month step per cycle through a shared add/subtract unit: an item is
// loaded, stepped across the months it crosses, then moved to the output.
// Input ready only while idle; a finished result parks in the output register,
// so the next transfer is taken while it waits.
// Output stall holds the sequencer on its last step until the register frees.
// Reset clears the sequencer and output valid only.
`include "calendar_day_normalizer_top_macros.svh"

module calendar_day_normalizer_top import cdn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  cdn_in_if.sink          in_i,
  cdn_out_if.source       out_o
);

  state_e                      state_q, state_d;
  logic [YEAR_BITS-1:0]        year_q, year_d;
  logic [MONTH_BITS-1:0]       month_q, month_d;
  logic signed [DAY_BITS-1:0]  day_q, day_d;
  logic                        err_q, err_d;

  logic                        out_valid_q, out_valid_d;
  logic [YEAR_BITS-1:0]        out_year_q;
  logic [MONTH_BITS-1:0]       out_month_q;
  logic [NDAY_BITS-1:0]        out_day_q;
  logic                        out_err_q;
  logic                        out_load;

  logic                        is_low, is_high, at_floor, at_ceil, step_done, out_free;
  logic [MONTH_BITS-1:0]       month_prev, lk_month;
  logic [YEAR_BITS-1:0]        year_prev;
  logic [1:0]                  lk_year;
  logic [NDAY_BITS-1:0]        len;
  logic signed [DAY_BITS-1:0]  len_s, sum;
  logic [MONTH_BITS-1:0]       in_month;

  assign is_low     = day_q[DAY_BITS-1] || (day_q == '0);
  assign month_prev = (month_q == MONTH_JAN) ? MONTH_DEC : month_q - MONTH_JAN;
  assign year_prev  = (month_q == MONTH_JAN) ? year_q - YEAR_BITS'(1) : year_q;
  assign lk_month   = is_low ? month_prev : month_q;
  assign lk_year    = is_low ? year_prev[1:0] : year_q[1:0];
  assign len        = month_len(lk_year, lk_month);
  assign len_s      = $signed({{(DAY_BITS-NDAY_BITS){1'b0}}, len});
  assign sum        = is_low ? day_q + len_s : day_q - len_s;
  assign is_high    = !is_low && !sum[DAY_BITS-1] && (sum != '0);
  assign step_done  = !is_low && !is_high;
  assign at_floor   = (month_q == MONTH_JAN) && (year_q == '0);
  assign at_ceil    = (month_q == MONTH_DEC) && (year_q == YEAR_MAX);
  assign out_free   = !out_valid_q || out_o.ready;

  assign in_month = (in_i.start_month == '0)      ? MONTH_JAN :
                    (in_i.start_month > MONTH_DEC) ? MONTH_DEC : in_i.start_month;

  always_comb begin
    state_d  = state_q;
    year_d   = year_q;
    month_d  = month_q;
    day_d    = day_q;
    err_d    = err_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          year_d  = in_i.start_year;
          month_d = in_month;
          day_d   = in_i.requested_day;
          err_d   = 1'b0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (step_done) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (is_low) begin
          if (at_floor) begin
            err_d   = 1'b1;
            month_d = MONTH_JAN;
            day_d   = DAY_BITS'(DAY_FIRST);
          end else begin
            year_d  = year_prev;
            month_d = month_prev;
            day_d   = sum;
          end
        end else begin
          if (at_ceil) begin
            err_d = 1'b1;
            day_d = DAY_BITS'(LEN_31);
          end else begin
            day_d = sum;
            if (month_q == MONTH_DEC) begin
              year_d  = year_q + YEAR_BITS'(1);
              month_d = MONTH_JAN;
            end else begin
              month_d = month_q + MONTH_JAN;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    year_q  <= year_d;
    month_q <= month_d;
    day_q   <= day_d;
    err_q   <= err_d;
    if (out_load) begin
      out_year_q  <= year_q;
      out_month_q <= month_q;
      out_day_q   <= day_q[NDAY_BITS-1:0];
      out_err_q   <= err_q;
    end
  end

  assign in_i.ready             = (state_q == S_IDLE);
  assign out_o.valid            = out_valid_q;
  assign out_o.norm_year        = out_year_q;
  assign out_o.norm_month       = out_month_q;
  assign out_o.norm_day         = out_day_q;
  assign out_o.packed_date      = {out_year_q, out_month_q, out_day_q};
  assign out_o.year_range_error = out_err_q;

  `CDN_ASSERT_NEXT(a_accept_starts_run, in_i.valid && in_i.ready, state_q == S_RUN)
  `CDN_ASSERT_IMPL(a_out_in_range, out_valid_q,
                   (out_day_q != '0) && (out_month_q != '0) && (out_month_q <= MONTH_DEC))
  `CDN_ASSERT_IMPL(a_floor_saturate, out_valid_q && out_err_q && (out_year_q == '0),
                   (out_month_q == MONTH_JAN) && (out_day_q == DAY_FIRST))
  `CDN_ASSERT_NEXT(a_err_finishes, (state_q == S_RUN) && err_q && !out_valid_q,
                   state_q == S_IDLE)
  `CDN_ASSERT(a_load_only_run, out_load |-> (state_q == S_RUN) && out_free)

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import cdn_pkg::*;

  typedef struct packed {
    logic [YEAR_BITS-1:0]   year;
    logic [MONTH_BITS-1:0]  month;
    logic [NDAY_BITS-1:0]   day;
    logic [PACKED_BITS-1:0] packed_date;
    logic                   range_err;
  } date_result_t;

  logic clk;
  logic rst_n;

  cdn_in_if  in_if ();
  cdn_out_if out_if ();

  calendar_day_normalizer_top DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  date_result_t pending_dates[$];
  int unsigned  mismatch_count = 0;
  int unsigned  result_count = 0;
  int           burst_left;
  bit           feeding;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic int month_length(int yr, int mo);
    if (mo == MONTH_FEB) begin
      return (yr % 4 == 0) ? LEN_29 : LEN_28;
    end
    if (mo == MONTH_APR || mo == MONTH_JUN || mo == MONTH_SEP || mo == MONTH_NOV) begin
      return LEN_30;
    end
    return LEN_31;
  endfunction

  function automatic date_result_t normalize_date(logic [YEAR_BITS-1:0] yr_in,
                                                  logic [MONTH_BITS-1:0] mo_in,
                                                  logic signed [DAY_BITS-1:0] day_in);
    date_result_t r;
    int yr;
    int mo;
    int dy;
    bit err;
    yr  = int'(yr_in);
    mo  = int'(mo_in);
    dy  = int'(day_in);
    err = 1'b0;
    if (mo < MONTH_JAN) mo = MONTH_JAN;
    if (mo > MONTH_DEC) mo = MONTH_DEC;
    while (dy < 1) begin
      if (mo == MONTH_JAN) begin
        if (yr == 0) begin
          err = 1'b1;
          dy  = DAY_FIRST;
          break;
        end
        yr = yr - 1;
        mo = MONTH_DEC;
      end else begin
        mo = mo - 1;
      end
      dy = dy + month_length(yr, mo);
    end
    while (!err && dy > month_length(yr, mo)) begin
      if (mo == MONTH_DEC && yr == YEAR_MAX) begin
        err = 1'b1;
        dy  = LEN_31;
        break;
      end
      dy = dy - month_length(yr, mo);
      if (mo == MONTH_DEC) begin
        yr = yr + 1;
        mo = MONTH_JAN;
      end else begin
        mo = mo + 1;
      end
    end
    r.year        = YEAR_BITS'(yr);
    r.month       = MONTH_BITS'(mo);
    r.day         = NDAY_BITS'(dy);
    r.packed_date = {r.year, r.month, r.day};
    r.range_err   = err;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("result %0d: %s is %0d, expected %0d", result_count, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_result
    date_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_dates.size() == 0) begin
        report_mismatch("unexpected transfer, packed_date", out_if.packed_date, 0);
      end else begin
        want = pending_dates.pop_front();
        if (out_if.norm_year !== want.year)
          report_mismatch("norm_year", out_if.norm_year, want.year);
        if (out_if.norm_month !== want.month)
          report_mismatch("norm_month", out_if.norm_month, want.month);
        if (out_if.norm_day !== want.day)
          report_mismatch("norm_day", out_if.norm_day, want.day);
        if (out_if.packed_date !== want.packed_date)
          report_mismatch("packed_date", out_if.packed_date, want.packed_date);
        if (out_if.year_range_error !== want.range_err)
          report_mismatch("year_range_error", out_if.year_range_error, want.range_err);
      end
      result_count++;
    end
  end

  // Stall pattern: free-flowing, coin-flip, or long alternating holds.
  int stall_mode = 0;
  int stall_span = 0;
  int hold_cnt = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_span <= $urandom_range(50, 400);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (hold_cnt == 0) begin
          out_if.ready <= !out_if.ready;
          hold_cnt     <= $urandom_range(1, 25);
        end else begin
          hold_cnt <= hold_cnt - 1;
        end
      end
    endcase
  end

  task automatic send_date(logic [YEAR_BITS-1:0] yr, logic [MONTH_BITS-1:0] mo,
                           logic signed [DAY_BITS-1:0] dy);
    in_if.start_year    <= yr;
    in_if.start_month   <= mo;
    in_if.requested_day <= dy;
    in_if.valid         <= 1'b1;
    feeding = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    pending_dates.push_back(normalize_date(yr, mo, dy));
    burst_left--;
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      feeding = 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  task automatic test_day_extremes();
    send_date(12'd2000, 4'd6, -11'sd1024);
    send_date(12'd2000, 4'd6, 11'sd1023);
    send_date(12'd2000, 4'd6, 11'sd0);
    send_date(12'd2000, 4'd6, 11'sd1);
    send_date(12'd2000, 4'd7, 11'sd31);
    send_date(12'd2000, 4'd6, 11'sd31);
  endtask

  task automatic test_month_clamp();
    send_date(12'd1999, 4'd0, 11'sd15);
    send_date(12'd1999, 4'd13, 11'sd15);
    send_date(12'd1999, 4'd15, 11'sd40);
    send_date(12'd1999, 4'd0, -11'sd3);
  endtask

  task automatic test_year_saturation();
    send_date(12'd0, 4'd1, 11'sd0);
    send_date(12'd0, 4'd1, -11'sd1024);
    send_date(12'd0, 4'd3, -11'sd100);
    send_date(12'd0, 4'd1, 11'sd1);
    send_date(YEAR_MAX, 4'd12, 11'sd32);
    send_date(YEAR_MAX, 4'd12, 11'sd1023);
    send_date(YEAR_MAX, 4'd1, 11'sd400);
    send_date(YEAR_MAX, 4'd12, 11'sd31);
  endtask

  task automatic test_leap_february();
    send_date(12'd2024, 4'd2, 11'sd29);
    send_date(12'd2023, 4'd2, 11'sd29);
    send_date(12'd2024, 4'd3, 11'sd0);
    send_date(12'd2023, 4'd3, 11'sd0);
    send_date(12'd2100, 4'd2, 11'sd29);
  endtask

  task automatic test_random_dates(int count);
    logic [YEAR_BITS-1:0]       yr;
    logic [MONTH_BITS-1:0]      mo;
    logic signed [DAY_BITS-1:0] dy;
    for (int i = 0; i < count; i++) begin
      yr = YEAR_BITS'($urandom);
      mo = MONTH_BITS'($urandom_range(1, 12));
      dy = DAY_BITS'($urandom);
      case ($urandom_range(0, 9))
        5, 6: mo = MONTH_BITS'($urandom);
        7: begin
          yr = YEAR_BITS'($urandom_range(0, 2));
          mo = MONTH_BITS'($urandom_range(1, 3));
          dy = DAY_BITS'(-int'($urandom_range(0, 1024)));
        end
        8: begin
          yr = YEAR_BITS'(int'(YEAR_MAX) - int'($urandom_range(0, 2)));
          mo = MONTH_BITS'($urandom_range(10, 12));
          dy = DAY_BITS'($urandom_range(0, 1023));
        end
        9: dy = DAY_BITS'(int'($urandom_range(0, 35)) - 2);
        default: ;
      endcase
      send_date(yr, mo, dy);
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.start_year     <= '0;
    in_if.start_month    <= '0;
    in_if.requested_day  <= '0;
    burst_left           = 4;
    feeding              = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_day_extremes();
    test_month_clamp();
    test_year_saturation();
    test_leap_february();
    test_random_dates(1527);

    if (feeding) in_if.valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
